// File: rtl/gmuf_pkg.sv
// Shared constants, codes and types of the grid maze union-find carver.
// Used by the interfaces, the controller, the datapath and the top level.
package gmuf_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int CELL_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int COLS_W   = $clog2(MAX_COLS + 1);

    // Fixed field widths of the ports.
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int DIR_W     = 2;
    localparam int CNT_W     = 8;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int RANK_W    = 4;
    localparam int WALL_W    = 4;
    localparam int WORD_W    = WALL_W + RANK_W + CELL_W;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 5'd3;
    localparam logic [CFG_W-1:0] COLS_RESET = 5'd2;

    localparam logic CMD_TRY     = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [DIR_W-1:0] DIR_N = 2'd0;
    localparam logic [DIR_W-1:0] DIR_E = 2'd1;
    localparam logic [DIR_W-1:0] DIR_S = 2'd2;
    localparam logic [DIR_W-1:0] DIR_W_ = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    // One memory word per cell.
    typedef struct packed {
        logic [WALL_W-1:0] walls;
        logic [RANK_W-1:0] rank;
        logic [CELL_W-1:0] parent;
    } t_word;

    // Which find is running: the two wall cells, then the two end cells.
    typedef enum logic [1:0] {
        PH_A  = 2'd0,
        PH_B  = 2'd1,
        PH_E0 = 2'd2,
        PH_EL = 2'd3
    } t_phase;

    // Read-modify-write targets of a removal.
    typedef enum logic [1:0] {
        TG_HERE  = 2'd0,
        TG_THERE = 2'd1,
        TG_CHILD = 2'd2,
        TG_PROOT = 2'd3
    } t_tgt;

    typedef struct packed {
        logic   accept;
        logic   find_start;
        logic   walk;
        logic   compress;
        logic   save;
        logic   rmw_rd;
        logic   rmw_wr;
        t_phase phase;
        t_tgt   tgt;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic wall_up;
        logic is_root;
        logic start_is_root;
        logic next_is_root;
        logic roots_differ;
        logic out_free;
    } t_status;

endpackage

// File: rtl/gmuf_in_if.sv
// Input channel of the carver: one command word per handshake.
// Depends on gmuf_pkg for the field widths.
interface gmuf_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [gmuf_pkg::ROW_W-1:0]     cell_row;
    logic [gmuf_pkg::COL_W-1:0]     cell_col;
    logic [gmuf_pkg::DIR_W-1:0]     wall_dir;

    modport source (output valid, command, cell_row, cell_col, wall_dir, input ready);
    modport sink   (input valid, command, cell_row, cell_col, wall_dir, output ready);
endinterface

// File: rtl/gmuf_out_if.sv
// Result channel of the carver: one result word per handshake.
// Depends on gmuf_pkg for the field widths.
interface gmuf_out_if;
    logic                           valid;
    logic                           ready;
    logic                           wall_removed;
    logic                           ends_connected;
    logic [gmuf_pkg::CNT_W-1:0]     removed_count;

    modport source (output valid, wall_removed, ends_connected, removed_count, input ready);
    modport sink   (input valid, wall_removed, ends_connected, removed_count, output ready);
endinterface

// File: rtl/gmuf_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on gmuf_pkg for the field widths.
interface gmuf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gmuf_pkg::CFG_IDX_W-1:0]     index;
    logic [gmuf_pkg::CFG_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/gmuf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gmuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/gmuf_ctrl.sv
// Controller of the carver: sequences the two wall finds, the merge writes
// and the two end-cell finds of each command. Depends on gmuf_pkg.
module gmuf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gmuf_pkg::t_status   i_status,
    output gmuf_pkg::t_cmd      o_cmd
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_WALL   = 9'b000000100,
        S_FSTART = 9'b000001000,
        S_FWALK  = 9'b000010000,
        S_FCOMP  = 9'b000100000,
        S_FDONE  = 9'b001000000,
        S_RMW_RD = 9'b010000000,
        S_RMW_WR = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    gmuf_pkg::t_phase r_phase, n_phase;
    gmuf_pkg::t_tgt   r_tgt, n_tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= gmuf_pkg::PH_A;
            r_tgt   <= gmuf_pkg::TG_HERE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_tgt   <= n_tgt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_tgt   = r_tgt;
        o_cmd   = '0;
        o_cmd.phase = r_phase;
        o_cmd.tgt   = r_tgt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.go) begin
                    // Fetch the chosen cell to see whether its wall is still up.
                    o_cmd.rmw_rd = 1'b1;
                    o_cmd.tgt    = gmuf_pkg::TG_HERE;
                    n_state = S_WALL;
                end else begin
                    n_phase = gmuf_pkg::PH_E0;
                    n_state = S_FSTART;
                end
            end
            S_WALL: begin
                n_phase = i_status.wall_up ? gmuf_pkg::PH_A : gmuf_pkg::PH_E0;
                n_state = S_FSTART;
            end
            S_FSTART: begin
                o_cmd.find_start = 1'b1;
                n_state = S_FWALK;
            end
            S_FWALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.is_root) begin
                    n_state = i_status.start_is_root ? S_FDONE : S_FCOMP;
                end
            end
            S_FCOMP: begin
                o_cmd.compress = 1'b1;
                if (i_status.next_is_root) begin
                    n_state = S_FDONE;
                end
            end
            S_FDONE: begin
                case (r_phase)
                    gmuf_pkg::PH_A: begin
                        o_cmd.save = 1'b1;
                        n_phase = gmuf_pkg::PH_B;
                        n_state = S_FSTART;
                    end
                    gmuf_pkg::PH_B: begin
                        o_cmd.save = 1'b1;
                        if (i_status.roots_differ) begin
                            n_tgt   = gmuf_pkg::TG_HERE;
                            n_state = S_RMW_RD;
                        end else begin
                            n_phase = gmuf_pkg::PH_E0;
                            n_state = S_FSTART;
                        end
                    end
                    gmuf_pkg::PH_E0: begin
                        o_cmd.save = 1'b1;
                        n_phase = gmuf_pkg::PH_EL;
                        n_state = S_FSTART;
                    end
                    gmuf_pkg::PH_EL: begin
                        // The result goes out only once the output register is free.
                        if (i_status.out_free) begin
                            o_cmd.save = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RMW_RD: begin
                o_cmd.rmw_rd = 1'b1;
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.rmw_wr = 1'b1;
                case (r_tgt)
                    gmuf_pkg::TG_HERE: begin
                        n_tgt   = gmuf_pkg::TG_THERE;
                        n_state = S_RMW_RD;
                    end
                    gmuf_pkg::TG_THERE: begin
                        n_tgt   = gmuf_pkg::TG_CHILD;
                        n_state = S_RMW_RD;
                    end
                    gmuf_pkg::TG_CHILD: begin
                        n_tgt   = gmuf_pkg::TG_PROOT;
                        n_state = S_RMW_RD;
                    end
                    gmuf_pkg::TG_PROOT: begin
                        n_phase = gmuf_pkg::PH_E0;
                        n_state = S_FSTART;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// File: rtl/gmuf_datapath.sv
// Datapath of the carver: configuration registers, cell memory with valid
// bits, find and merge registers, and the result register.
// Depends on gmuf_pkg and gmuf_ram.
module gmuf_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gmuf_pkg::t_cmd                  i_cmd,
    output gmuf_pkg::t_status               o_status,
    input  logic                            i_command,
    input  logic [gmuf_pkg::ROW_W-1:0]      i_cell_row,
    input  logic [gmuf_pkg::COL_W-1:0]      i_cell_col,
    input  logic [gmuf_pkg::DIR_W-1:0]      i_wall_dir,
    input  logic                            i_cfg_valid,
    input  logic [gmuf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gmuf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_wall_removed,
    output logic                            o_ends_connected,
    output logic [gmuf_pkg::CNT_W-1:0]      o_removed_count
);
    localparam int CW = gmuf_pkg::CELL_W;

    logic [gmuf_pkg::CFG_W-1:0]  r_grid_rows, r_grid_cols;
    logic [gmuf_pkg::ROWS_W-1:0] used_rows;
    logic [gmuf_pkg::COLS_W-1:0] used_cols;

    logic                        r_command;
    logic [gmuf_pkg::ROW_W-1:0]  r_row;
    logic [gmuf_pkg::COL_W-1:0]  r_col;
    logic [gmuf_pkg::DIR_W-1:0]  r_dir;
    logic [gmuf_pkg::DIR_W-1:0]  dir2;
    logic                        in_grid, perimeter;
    logic [CW-1:0]               here, there, last;

    logic [gmuf_pkg::CELLS-1:0]  r_valid;
    logic                        r_rd_valid;
    logic [CW-1:0]               r_rd_addr;
    logic [gmuf_pkg::WORD_W-1:0] ram_q, ram_wdata;
    logic                        ram_re, ram_we;
    logic [CW-1:0]               ram_raddr, ram_waddr;
    gmuf_pkg::t_word             word, wword;

    logic [CW-1:0]               r_start, r_cur, r_root, r_ra, r_rb;
    logic [gmuf_pkg::RANK_W-1:0] r_root_rank, r_rank_a, r_rank_b;
    logic                        r_removed;
    logic [gmuf_pkg::CNT_W-1:0]  r_count;
    logic                        r_out_valid, r_out_removed, r_out_ends;
    logic [gmuf_pkg::CNT_W-1:0]  r_out_count;

    logic                        a_over_b, is_root;
    logic [CW-1:0]               src_addr, tgt_addr;

    // Register values out of range are used clamped to 1..MAX.
    always_comb begin
        if (r_grid_rows == '0) begin
            used_rows = gmuf_pkg::ROWS_W'(1);
        end else if (int'(r_grid_rows) > gmuf_pkg::MAX_ROWS) begin
            used_rows = gmuf_pkg::ROWS_W'(gmuf_pkg::MAX_ROWS);
        end else begin
            used_rows = gmuf_pkg::ROWS_W'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            used_cols = gmuf_pkg::COLS_W'(1);
        end else if (int'(r_grid_cols) > gmuf_pkg::MAX_COLS) begin
            used_cols = gmuf_pkg::COLS_W'(gmuf_pkg::MAX_COLS);
        end else begin
            used_cols = gmuf_pkg::COLS_W'(r_grid_cols);
        end
    end

    assign in_grid = (int'(r_row) < int'(used_rows)) && (int'(r_col) < int'(used_cols));
    assign here    = CW'(int'(r_row) * gmuf_pkg::MAX_COLS + int'(r_col));
    assign last    = CW'((int'(used_rows) - 1) * gmuf_pkg::MAX_COLS + int'(used_cols) - 1);
    // The opposite side is two directions away.
    assign dir2    = {~r_dir[1], r_dir[0]};

    always_comb begin
        case (r_dir)
            gmuf_pkg::DIR_N: begin
                perimeter = (r_row == '0);
                there     = CW'(int'(here) - gmuf_pkg::MAX_COLS);
            end
            gmuf_pkg::DIR_E: begin
                perimeter = (int'(r_col) == int'(used_cols) - 1);
                there     = CW'(int'(here) + 1);
            end
            gmuf_pkg::DIR_S: begin
                perimeter = (int'(r_row) == int'(used_rows) - 1);
                there     = CW'(int'(here) + gmuf_pkg::MAX_COLS);
            end
            gmuf_pkg::DIR_W_: begin
                perimeter = (r_col == '0);
                there     = CW'(int'(here) - 1);
            end
            default: begin
                perimeter = 1'b1;
                there     = here;
            end
        endcase
    end

    // A cell never written since the last restart reads as its initial word.
    always_comb begin
        if (r_rd_valid) begin
            word = gmuf_pkg::t_word'(ram_q);
        end else begin
            word.walls  = '1;
            word.rank   = '0;
            word.parent = r_rd_addr;
        end
    end

    assign is_root  = (word.parent == r_cur);
    assign a_over_b = (r_rank_a > r_rank_b);

    always_comb begin
        case (i_cmd.phase)
            gmuf_pkg::PH_A:  src_addr = here;
            gmuf_pkg::PH_B:  src_addr = there;
            gmuf_pkg::PH_E0: src_addr = '0;
            gmuf_pkg::PH_EL: src_addr = last;
            default:         src_addr = '0;
        endcase
        case (i_cmd.tgt)
            gmuf_pkg::TG_HERE:  tgt_addr = here;
            gmuf_pkg::TG_THERE: tgt_addr = there;
            gmuf_pkg::TG_CHILD: tgt_addr = a_over_b ? r_rb : r_ra;
            gmuf_pkg::TG_PROOT: tgt_addr = a_over_b ? r_ra : r_rb;
            default:            tgt_addr = here;
        endcase
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (i_cmd.find_start) begin
            ram_re    = 1'b1;
            ram_raddr = src_addr;
        end else if (i_cmd.walk) begin
            // At the root, the compression walk starts over from the start cell of the find.
            ram_re    = 1'b1;
            ram_raddr = is_root ? r_start : word.parent;
        end else if (i_cmd.compress) begin
            ram_re    = 1'b1;
            ram_raddr = word.parent;
        end else if (i_cmd.rmw_rd) begin
            ram_re    = 1'b1;
            ram_raddr = tgt_addr;
        end
    end

    always_comb begin
        wword     = word;
        ram_we    = 1'b0;
        ram_waddr = tgt_addr;
        if (i_cmd.compress) begin
            ram_we       = 1'b1;
            ram_waddr    = r_cur;
            wword.parent = r_root;
        end else if (i_cmd.rmw_wr) begin
            ram_we = 1'b1;
            case (i_cmd.tgt)
                gmuf_pkg::TG_HERE:  wword.walls[r_dir] = 1'b0;
                gmuf_pkg::TG_THERE: wword.walls[dir2]  = 1'b0;
                gmuf_pkg::TG_CHILD: wword.parent = a_over_b ? r_ra : r_rb;
                gmuf_pkg::TG_PROOT: begin
                    if (!a_over_b && (r_rank_a == r_rank_b) && (word.rank < gmuf_pkg::RANK_MAX)) begin
                        wword.rank = word.rank + 1'b1;
                    end
                end
                default: wword = word;
            endcase
        end
    end

    assign ram_wdata = wword;

    gmuf_ram #(
        .WIDTH (gmuf_pkg::WORD_W),
        .DEPTH (gmuf_pkg::CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Control state: configuration, valid bits, counters, result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= gmuf_pkg::ROWS_RESET;
            r_grid_cols <= gmuf_pkg::COLS_RESET;
            r_valid     <= '0;
            r_count     <= '0;
            r_removed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gmuf_pkg::CFG_ROWS: r_grid_rows <= i_cfg_data;
                    gmuf_pkg::CFG_COLS: r_grid_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_removed <= 1'b0;
                if (i_command == gmuf_pkg::CMD_RESTART) begin
                    r_valid <= '0;
                    r_count <= '0;
                end
            end else if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (i_cmd.save && (i_cmd.phase == gmuf_pkg::PH_B) && (r_root != r_ra)) begin
                r_removed <= 1'b1;
                if (r_count != gmuf_pkg::CNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.save && (i_cmd.phase == gmuf_pkg::PH_EL)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_command <= i_command;
            r_row     <= i_cell_row;
            r_col     <= i_cell_col;
            r_dir     <= i_wall_dir;
        end
        if (ram_re) begin
            r_rd_valid <= r_valid[ram_raddr];
            r_rd_addr  <= ram_raddr;
        end
        if (i_cmd.find_start) begin
            r_start <= src_addr;
            r_cur   <= src_addr;
        end else if (i_cmd.walk) begin
            r_cur <= ram_raddr;
            if (is_root) begin
                r_root      <= r_cur;
                r_root_rank <= word.rank;
            end
        end else if (i_cmd.compress) begin
            r_cur <= word.parent;
        end
        if (i_cmd.save) begin
            case (i_cmd.phase)
                gmuf_pkg::PH_A: begin
                    r_ra     <= r_root;
                    r_rank_a <= r_root_rank;
                end
                gmuf_pkg::PH_B: begin
                    r_rb     <= r_root;
                    r_rank_b <= r_root_rank;
                end
                gmuf_pkg::PH_E0: begin
                    r_ra <= r_root;
                end
                gmuf_pkg::PH_EL: begin
                    r_out_removed <= r_removed;
                    r_out_ends    <= (r_ra == r_root);
                    r_out_count   <= r_count;
                end
                default: ;
            endcase
        end
    end

    assign o_status.go            = (r_command == gmuf_pkg::CMD_TRY) && in_grid && !perimeter;
    assign o_status.wall_up       = word.walls[r_dir];
    assign o_status.is_root       = is_root;
    assign o_status.start_is_root = (r_start == r_cur);
    assign o_status.next_is_root  = (word.parent == r_root);
    assign o_status.roots_differ  = (r_root != r_ra);
    assign o_status.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_wall_removed   = r_out_removed;
    assign o_ends_connected = r_out_ends;
    assign o_removed_count  = r_out_count;
endmodule

// File: rtl/grid_maze_union_find_carver_top.sv
// Grid maze union-find carver, one command word at a time. A try on a standing inner wall runs
// two finds, one from each cell of the wall (each walks the hops to the root, and walks them again
// to compress if the start is not the root), the merge read-modify-writes if the wall falls, then
// two end-cell finds; a fallen wall skips the first finds, a restart or ignored try runs only the
// end-cell finds. The result is valid and the input ready the next cycle after the result load; a
// held result stalls the last find. Synchronous active-low reset restores the initial grid at once.
module grid_maze_union_find_carver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gmuf_in_if.sink     i_in,
    gmuf_out_if.source  o_out,
    gmuf_cfg_if.sink    i_cfg
);
    gmuf_pkg::t_cmd    cmd;
    gmuf_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    gmuf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gmuf_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_command        (i_in.command),
        .i_cell_row       (i_in.cell_row),
        .i_cell_col       (i_in.cell_col),
        .i_wall_dir       (i_in.wall_dir),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_wall_removed   (o_out.wall_removed),
        .o_ends_connected (o_out.ends_connected),
        .o_removed_count  (o_out.removed_count)
    );
endmodule
